FILE: src/value_noise_terrain_height_top_macros.svh
// assertion macros for the value noise terrain height block
// no dependencies; taken in by the top level
`ifndef VALUE_NOISE_TERRAIN_HEIGHT_TOP_MACROS_SVH
`define VALUE_NOISE_TERRAIN_HEIGHT_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// antecedent implies consequent in the same cycle
`define VNTH_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error("vnth assertion failed");

// antecedent implies consequent a fixed number of cycles later
`define VNTH_ASSERT_DLY(lbl, clk_s, rstn_s, ante, dly, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> ##dly (cons)) \
		else $error("vnth assertion failed");

`else

`define VNTH_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons)
`define VNTH_ASSERT_DLY(lbl, clk_s, rstn_s, ante, dly, cons)

`endif

`endif

FILE: src/vnth_pkg.sv
// shared constants and types for the value noise terrain height block
// no dependencies
package vnth_pkg;

	// default parameter values
	localparam int DEF_COORD_BITS    = 24;
	localparam int DEF_FRAC_BITS     = 16;
	localparam int DEF_HEIGHT_LEVELS = 64;

	// lattice hash constants
	localparam logic [31:0] HASH_MUL_B   = 32'd57;
	localparam logic [31:0] HASH_MUL_S   = 32'd131;
	localparam int          HASH_SHIFT   = 13;
	localparam logic [31:0] HASH_MUL_SQ  = 32'd15731;
	localparam logic [31:0] HASH_ADD_SQ  = 32'd789221;
	localparam logic [31:0] HASH_ADD_OUT = 32'd1376312589;
	localparam logic [31:0] HASH_HALF    = 32'd1073741824;

	// register stages: one scaling stage, four hash stages, four blend, two height
	localparam int PIPE_LAT    = 11;

	// register reset values
	localparam logic [31:0] RST_NOISE_SEED  = 32'd12345;
	localparam logic [15:0] RST_FREQ        = 16'd3277;
	localparam int          RST_BASE        = 25;
	localparam int          RST_SCALE       = 15;
	localparam int          RST_MIN         = 5;
	localparam int          RST_MAX         = 54;
	localparam logic [31:0] RST_TREE_SEED   = 32'd54321;
	localparam logic [30:0] RST_TREE_LIMIT  = 31'd139586437;

	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 32;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_NOISE_SEED  = 3'd0,
		REG_FREQ        = 3'd1,
		REG_BASE        = 3'd2,
		REG_SCALE       = 3'd3,
		REG_MIN         = 3'd4,
		REG_MAX         = 3'd5,
		REG_TREE_SEED   = 3'd6,
		REG_TREE_LIMIT  = 3'd7
	} cfg_reg_t;

endpackage

FILE: src/vnth_hash.sv
// four-stage pipelined 32-bit lattice hash
// depends on vnth_pkg
module vnth_hash import vnth_pkg::*; (
	input  logic        clk,
	input  logic [31:0] a,
	input  logic [31:0] b,
	input  logic [31:0] seed,
	output logic [30:0] h
);

	logic [31:0] n_mix;
	logic [31:0] n_s1, n_s2, n_s3;
	logic [31:0] sq_s2;
	logic [31:0] m_s3;
	logic [30:0] h_s4;
	logic [31:0] prod;

	always_comb begin
		n_mix = a + b * HASH_MUL_B + seed * HASH_MUL_S;
		n_mix = (n_mix << HASH_SHIFT) ^ n_mix;
		prod  = n_s3 * m_s3 + HASH_ADD_OUT;
	end

	always_ff @(posedge clk) begin
		n_s1  <= n_mix;
		n_s2  <= n_s1;
		sq_s2 <= n_s1 * n_s1;
		n_s3  <= n_s2;
		m_s3  <= sq_s2 * HASH_MUL_SQ + HASH_ADD_SQ;
		h_s4  <= prod[30:0];
	end

	assign h = h_s4;

endmodule

FILE: src/vnth_blend.sv
// four-stage bilinear blend of the hashed corner values
// depends on vnth_pkg
module vnth_blend import vnth_pkg::*; #(
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [30:0]                   h00,
	input  logic [30:0]                   h10,
	input  logic [30:0]                   h01,
	input  logic [30:0]                   h11,
	input  logic [FRAC_BITS-1:0]          fx,
	input  logic [FRAC_BITS-1:0]          fz,
	output logic                          out_valid,
	output logic signed [FRAC_BITS+1:0]   noise
);

	localparam int F   = FRAC_BITS;
	localparam int VW  = F + 2;
	localparam int PW  = 2 * F + 4;
	localparam int HW  = F + 4;
	localparam int QW  = 2 * F + 6;
	localparam int LW  = 2 * F + 2;
	localparam logic [F:0] ONE = (F+1)'(1) << F;

	logic signed [31:0]   d00, d10, d01, d11;
	logic signed [VW-1:0] v00, v10, v01, v11;
	logic [F:0]           wx0, wz0;
	logic signed [PW-1:0] p00, p10, p01, p11;

	logic                 v_b1, v_b2, v_b3, v_b4;
	logic signed [PW-1:0] p00_b1, p10_b1, p01_b1, p11_b1;
	logic [F-1:0]         fz_b1, fz_b2;
	logic signed [PW-1:0] r0_b2, r1_b2;
	logic signed [HW-1:0] h0, h1;
	logic signed [QW-1:0] q0, q1;
	logic [LW-1:0]        l0w, l1w;
	logic signed [QW-1:0] q0_b3, q1_b3;
	logic [LW-1:0]        l0_b3, l1_b3;
	logic signed [QW-1:0] hi_sum, tot;
	logic [LW-1:0]        lo_sum;
	logic signed [VW-1:0] noise_b4;

	// corner value is (2^30 - h) >>> (30 - F), i.e. the top bits of the difference
	always_comb begin
		d00 = $signed(HASH_HALF) - $signed({1'b0, h00});
		d10 = $signed(HASH_HALF) - $signed({1'b0, h10});
		d01 = $signed(HASH_HALF) - $signed({1'b0, h01});
		d11 = $signed(HASH_HALF) - $signed({1'b0, h11});
		v00 = d00[31:30-F];
		v10 = d10[31:30-F];
		v01 = d01[31:30-F];
		v11 = d11[31:30-F];
		wx0 = ONE - {1'b0, fx};
		p00 = PW'(v00) * PW'($signed({1'b0, wx0}));
		p10 = PW'(v10) * PW'($signed({1'b0, 1'b0, fx}));
		p01 = PW'(v01) * PW'($signed({1'b0, wx0}));
		p11 = PW'(v11) * PW'($signed({1'b0, 1'b0, fx}));
	end

	// rows split into high and low halves before the z blend
	always_comb begin
		wz0 = ONE - {1'b0, fz_b2};
		h0  = HW'(r0_b2 >>> F);
		h1  = HW'(r1_b2 >>> F);
		q0  = QW'(h0) * QW'($signed({1'b0, wz0}));
		q1  = QW'(h1) * QW'($signed({1'b0, 1'b0, fz_b2}));
		l0w = LW'(r0_b2[F-1:0]) * LW'(wz0);
		l1w = LW'(r1_b2[F-1:0]) * LW'(fz_b2);
	end

	always_comb begin
		hi_sum = q0_b3 + q1_b3;
		lo_sum = l0_b3 + l1_b3;
		tot    = hi_sum + QW'($signed({1'b0, lo_sum[LW-1:F]}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_b1 <= 1'b0;
			v_b2 <= 1'b0;
			v_b3 <= 1'b0;
			v_b4 <= 1'b0;
		end else begin
			v_b1 <= in_valid;
			v_b2 <= v_b1;
			v_b3 <= v_b2;
			v_b4 <= v_b3;
		end
	end

	always_ff @(posedge clk) begin
		p00_b1   <= p00;
		p10_b1   <= p10;
		p01_b1   <= p01;
		p11_b1   <= p11;
		fz_b1    <= fz;
		r0_b2    <= p00_b1 + p10_b1;
		r1_b2    <= p01_b1 + p11_b1;
		fz_b2    <= fz_b1;
		q0_b3    <= q0;
		q1_b3    <= q1;
		l0_b3    <= l0w;
		l1_b3    <= l1w;
		noise_b4 <= tot[2*F+1:F];
	end

	assign out_valid = v_b4;
	assign noise     = noise_b4;

endmodule

FILE: src/vnth_height.sv
// two-stage noise scaling, truncation and clamping to a terrain height
// depends on vnth_pkg
module vnth_height import vnth_pkg::*; #(
	parameter int FRAC_BITS     = DEF_FRAC_BITS,
	parameter int HEIGHT_LEVELS = DEF_HEIGHT_LEVELS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic signed [FRAC_BITS+1:0]         noise_in,
	input  logic [$clog2(HEIGHT_LEVELS)-1:0]    base,
	input  logic [$clog2(HEIGHT_LEVELS)-1:0]    scale,
	input  logic [$clog2(HEIGHT_LEVELS)-1:0]    hmin,
	input  logic [$clog2(HEIGHT_LEVELS)-1:0]    hmax,
	output logic                                out_valid,
	output logic signed [FRAC_BITS+1:0]         noise_out,
	output logic [$clog2(HEIGHT_LEVELS)-1:0]    height
);

	localparam int F  = FRAC_BITS;
	localparam int HB = $clog2(HEIGHT_LEVELS);
	localparam int NW = F + 2;
	localparam int TW = NW + HB + 1;

	logic                 v_s10, v_s11;
	logic signed [TW-1:0] t_s10;
	logic signed [NW-1:0] noise_s10, noise_s11;
	logic [HB-1:0]        height_s11;

	logic                 neg;
	logic [TW-1:0]        mag;
	logic [HB-1:0]        qm;
	logic signed [HB+1:0] q, hraw, hcap, hclamp;

	// truncation toward zero: shift the magnitude, then restore the sign
	always_comb begin
		neg    = t_s10[TW-1];
		mag    = neg ? TW'(-t_s10) : TW'(t_s10);
		qm     = mag[F+HB-1:F];
		q      = neg ? -$signed({2'b00, qm}) : $signed({2'b00, qm});
		hraw   = $signed({2'b00, base}) + q;
		hcap   = (hraw > $signed({2'b00, hmax})) ? $signed({2'b00, hmax}) : hraw;
		hclamp = (hcap < $signed({2'b00, hmin})) ? $signed({2'b00, hmin}) : hcap;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
		end else begin
			v_s10 <= in_valid;
			v_s11 <= v_s10;
		end
	end

	always_ff @(posedge clk) begin
		t_s10      <= TW'(noise_in) * TW'($signed({1'b0, scale}));
		noise_s10  <= noise_in;
		noise_s11  <= noise_s10;
		height_s11 <= hclamp[HB-1:0];
	end

	assign out_valid = v_s11;
	assign noise_out = noise_s11;
	assign height    = height_s11;

endmodule

FILE: src/value_noise_terrain_height_top.sv
// value noise terrain height: top level with register file and pipeline front end
// depends on vnth_pkg, vnth_hash, vnth_blend, vnth_height and the assertion macros
//
// One world column (world_x, world_z) is taken per clock cycle whenever start is
// high; busy never rises, so a transfer happens on every such cycle. Each column
// gives exactly one result, shown on noise_value, terrain_height and tree_candidate
// for the single cycle in which done is high. The receiver cannot stall the block,
// and none is needed: results leave in input order at the input rate. The
// pipeline is built as follows: one stage scales the coordinate into lattice
// units, four stages run the integer hash (two 32x32 multiplies and three
// constant multiplies, each registered), four stages do the bilinear blend and
// two scale, truncate and clamp the height. Configuration is written through
// cfg_valid/cfg_ready/cfg_index/cfg_data (always ready) and must only change
// while no column is in flight.
`include "value_noise_terrain_height_top_macros.svh"

module value_noise_terrain_height_top import vnth_pkg::*; #(
	parameter int COORD_BITS    = DEF_COORD_BITS,
	parameter int FRAC_BITS     = DEF_FRAC_BITS,
	parameter int HEIGHT_LEVELS = DEF_HEIGHT_LEVELS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// command channel
	input  logic                                start,
	output logic                                busy,
	input  logic signed [COORD_BITS-1:0]        world_x,
	input  logic signed [COORD_BITS-1:0]        world_z,
	// result strobe
	output logic                                done,
	output logic signed [FRAC_BITS+1:0]         noise_value,
	output logic [$clog2(HEIGHT_LEVELS)-1:0]    terrain_height,
	output logic                                tree_candidate,
	// configuration write channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [CFG_IDX_BITS-1:0]             cfg_index,
	input  logic [CFG_DATA_BITS-1:0]            cfg_data
);

	localparam int F   = FRAC_BITS;
	localparam int HB  = $clog2(HEIGHT_LEVELS);
	localparam int NW  = F + 2;
	localparam int PXW = COORD_BITS + 17;
	localparam logic signed [NW-1:0] NOISE_HI = NW'(1) << F;
	localparam logic signed [NW-1:0] NOISE_LO = -(NW'(1) << F);

	// configuration registers
	logic [31:0]   noise_seed_q;
	logic [15:0]   freq_q;
	logic [HB-1:0] base_q, scale_q, hmin_q, hmax_q;
	logic [31:0]   tree_seed_q;
	logic [30:0]   tree_limit_q;
	logic          cfg_we;

	// front end pipeline
	logic                  in_xfer;
	logic                  v_s1, v_s2, v_s3, v_s4, v_s5;
	logic signed [PXW-1:0] px_s1, pz_s1;
	logic signed [31:0]    xe_s1, ze_s1;
	logic [F-1:0]          fx_s2, fx_s3, fx_s4, fx_s5;
	logic [F-1:0]          fz_s2, fz_s3, fz_s4, fz_s5;

	// lattice cell, corner offsets and fraction taken from the scaled coordinate
	logic [31:0]  cx, cz, cx1, cz1;
	logic [F-1:0] fx, fz;

	// hash outputs, aligned with stage 5
	logic [30:0] h00, h10, h01, h11, th;

	// tree flag carried alongside the blend and height stages
	logic tree_s6, tree_s7, tree_s8, tree_s9, tree_s10, tree_s11;

	logic                 bl_valid;
	logic signed [NW-1:0] bl_noise;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign in_xfer   = start & ~busy;
	assign cfg_we    = cfg_valid & cfg_ready;

	// register file: height registers keep only the bits the height range needs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			noise_seed_q <= RST_NOISE_SEED;
			freq_q       <= RST_FREQ;
			base_q       <= HB'(RST_BASE);
			scale_q      <= HB'(RST_SCALE);
			hmin_q       <= HB'(RST_MIN);
			hmax_q       <= HB'(RST_MAX);
			tree_seed_q  <= RST_TREE_SEED;
			tree_limit_q <= RST_TREE_LIMIT;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_NOISE_SEED: noise_seed_q <= cfg_data;
				REG_FREQ:       freq_q       <= cfg_data[15:0];
				REG_BASE:       base_q       <= cfg_data[HB-1:0];
				REG_SCALE:      scale_q      <= cfg_data[HB-1:0];
				REG_MIN:        hmin_q       <= cfg_data[HB-1:0];
				REG_MAX:        hmax_q       <= cfg_data[HB-1:0];
				REG_TREE_SEED:  tree_seed_q  <= cfg_data;
				REG_TREE_LIMIT: tree_limit_q <= cfg_data[30:0];
				default: begin
				end
			endcase
		end
	end

	// valid bits follow the data through the front end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= in_xfer;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// stage 1: scale the coordinates by the Q0.F frequency (signed by unsigned)
	always_ff @(posedge clk) begin
		px_s1 <= PXW'(world_x) * PXW'($signed({1'b0, freq_q}));
		pz_s1 <= PXW'(world_z) * PXW'($signed({1'b0, freq_q}));
		xe_s1 <= 32'(world_x);
		ze_s1 <= 32'(world_z);
	end

	// floor by arithmetic shift, cell wraps to 32 bits for hashing
	always_comb begin
		cx  = 32'(px_s1 >>> F);
		cz  = 32'(pz_s1 >>> F);
		cx1 = cx + 32'd1;
		cz1 = cz + 32'd1;
		fx  = px_s1[F-1:0];
		fz  = pz_s1[F-1:0];
	end

	// fractions wait for the hash pipeline
	always_ff @(posedge clk) begin
		fx_s2 <= fx;
		fx_s3 <= fx_s2;
		fx_s4 <= fx_s3;
		fx_s5 <= fx_s4;
		fz_s2 <= fz;
		fz_s3 <= fz_s2;
		fz_s4 <= fz_s3;
		fz_s5 <= fz_s4;
	end

	// stages 2 to 5: four corner hashes and the tree hash run side by side
	vnth_hash u_hash00 (.clk(clk), .a(cx),  .b(cz),  .seed(noise_seed_q), .h(h00));
	vnth_hash u_hash10 (.clk(clk), .a(cx1), .b(cz),  .seed(noise_seed_q), .h(h10));
	vnth_hash u_hash01 (.clk(clk), .a(cx),  .b(cz1), .seed(noise_seed_q), .h(h01));
	vnth_hash u_hash11 (.clk(clk), .a(cx1), .b(cz1), .seed(noise_seed_q), .h(h11));
	vnth_hash u_hash_tree (
		.clk (clk),
		.a   (xe_s1),
		.b   (ze_s1),
		.seed(tree_seed_q),
		.h   (th)
	);

	// tree compare at stage 6, then delayed to line up with the height output
	always_ff @(posedge clk) begin
		tree_s6  <= (th <= tree_limit_q);
		tree_s7  <= tree_s6;
		tree_s8  <= tree_s7;
		tree_s9  <= tree_s8;
		tree_s10 <= tree_s9;
		tree_s11 <= tree_s10;
	end

	// stages 6 to 9: bilinear blend
	vnth_blend #(
		.FRAC_BITS(FRAC_BITS)
	) u_blend (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s5),
		.h00      (h00),
		.h10      (h10),
		.h01      (h01),
		.h11      (h11),
		.fx       (fx_s5),
		.fz       (fz_s5),
		.out_valid(bl_valid),
		.noise    (bl_noise)
	);

	// stages 10 and 11: scale, truncate and clamp; stage 11 is the output register
	vnth_height #(
		.FRAC_BITS    (FRAC_BITS),
		.HEIGHT_LEVELS(HEIGHT_LEVELS)
	) u_height (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (bl_valid),
		.noise_in (bl_noise),
		.base     (base_q),
		.scale    (scale_q),
		.hmin     (hmin_q),
		.hmax     (hmax_q),
		.out_valid(done),
		.noise_out(noise_value),
		.height   (terrain_height)
	);

	assign tree_candidate = tree_s11;

	// every transfer gives its result a fixed number of cycles later, and no other
	`VNTH_ASSERT_DLY(a_lat_fwd, clk, arst_n, in_xfer, PIPE_LAT, done)
	`VNTH_ASSERT_IMP(a_lat_back, clk, arst_n, done, $past(in_xfer, PIPE_LAT))
	// the lower clamp is applied last, so it always holds
	`VNTH_ASSERT_IMP(a_height_min, clk, arst_n, done, terrain_height >= $past(hmin_q))
	// a blend of corner values in [-1, 1] stays in that range
	`VNTH_ASSERT_IMP(a_noise_range, clk, arst_n, done, (noise_value <= NOISE_HI) && (noise_value >= NOISE_LO))

endmodule
